[sv/mexp_pkg.sv]
// Shared types, constants and the control program of the modular exponentiation block.
`default_nettype none
package mexp_pkg;

  localparam int OPERAND_BITS = 16;
  localparam int PROD_BITS = 2 * OPERAND_BITS;
  localparam int RED_STEPS = PROD_BITS / 2;         // two remainder bits per cycle
  localparam int RED_CNT_BITS = $clog2(RED_STEPS);
  localparam int BIT_CNT_BITS = $clog2(OPERAND_BITS + 1);
  localparam int STEP_BITS = 3;

  localparam logic [OPERAND_BITS-1:0] MODULUS_RESET = OPERAND_BITS'(19211);

  typedef logic [STEP_BITS-1:0] step_t;

  // program steps
  localparam step_t S_IDLE    = 3'd0;
  localparam step_t S_BASE_WB = 3'd1;
  localparam step_t S_TEST    = 3'd2;
  localparam step_t S_MUL_GO  = 3'd3;
  localparam step_t S_MUL_WB  = 3'd4;
  localparam step_t S_SQ_GO   = 3'd5;
  localparam step_t S_SQ_WB   = 3'd6;
  localparam step_t S_FINISH  = 3'd7;

  typedef enum logic [1:0] {
    RED_BASE,
    RED_ACC,
    RED_SQ
  } red_op_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_SQ,
    WR_ACC
  } wr_sel_t;

  typedef enum logic [2:0] {
    JC_NONE,
    JC_ALWAYS,
    JC_WAIT_START,
    JC_BIT_CLR,
    JC_MORE_BITS
  } jcond_t;

  typedef struct packed {
    red_op_t red_op;
    logic    go;
    logic    wait_red;
    wr_sel_t wr;
    logic    shift_e;
    jcond_t  jc;
    step_t   target;
    logic    finish;
  } ctrl_t;

  typedef struct packed {
    logic red_done;
    logic e_bit0;
    logic last_bit;
  } stat_t;

  // control store
  function automatic ctrl_t ucode(input step_t step);
    ctrl_t w;
    w = '{red_op: RED_BASE, go: 1'b0, wait_red: 1'b0, wr: WR_NONE,
          shift_e: 1'b0, jc: JC_NONE, target: S_IDLE, finish: 1'b0};
    case (step)
      S_IDLE: begin
        w.go = 1'b1;              // gated by accept
        w.red_op = RED_BASE;
        w.jc = JC_WAIT_START;
        w.target = S_IDLE;
      end
      S_BASE_WB: begin
        w.wait_red = 1'b1;
        w.wr = WR_SQ;
      end
      S_TEST: begin
        w.jc = JC_BIT_CLR;
        w.target = S_SQ_GO;
      end
      S_MUL_GO: begin
        w.go = 1'b1;
        w.red_op = RED_ACC;
      end
      S_MUL_WB: begin
        w.wait_red = 1'b1;
        w.wr = WR_ACC;
      end
      S_SQ_GO: begin
        w.go = 1'b1;
        w.red_op = RED_SQ;
      end
      S_SQ_WB: begin
        w.wait_red = 1'b1;
        w.wr = WR_SQ;
        w.shift_e = 1'b1;
        w.jc = JC_MORE_BITS;
        w.target = S_TEST;
      end
      S_FINISH: begin
        w.finish = 1'b1;
        w.jc = JC_ALWAYS;
        w.target = S_IDLE;
      end
      default: begin
        w.jc = JC_ALWAYS;
        w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

[sv/mexp_modred.sv]
// Iterative remainder unit: 32-bit value mod 16-bit modulus, two bits per cycle.
`default_nettype none
module mexp_modred
  import mexp_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    go,
  input  wire logic [PROD_BITS-1:0]    value,
  input  wire logic [OPERAND_BITS-1:0] m,
  output logic                         done,
  output logic [OPERAND_BITS-1:0]      rem
);

  logic                    busy;
  logic [RED_CNT_BITS-1:0] cnt;
  logic [PROD_BITS-1:0]    val;
  logic [OPERAND_BITS-1:0] rem_mid;
  logic [OPERAND_BITS-1:0] rem_next;

  // one restoring step; partial remainder stays below m
  function automatic logic [OPERAND_BITS-1:0] rstep(input logic [OPERAND_BITS-1:0] r,
                                                    input logic b,
                                                    input logic [OPERAND_BITS-1:0] md);
    logic [OPERAND_BITS:0] t;
    t = {r, b};
    if (t >= {1'b0, md}) begin
      t = t - {1'b0, md};
    end
    return t[OPERAND_BITS-1:0];
  endfunction

  assign rem_mid  = rstep(rem, val[PROD_BITS-1], m);
  assign rem_next = rstep(rem_mid, val[PROD_BITS-2], m);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + RED_CNT_BITS'(1);
        if (cnt == RED_CNT_BITS'(RED_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      val <= value;
      rem <= '0;
    end else if (busy) begin
      val <= {val[PROD_BITS-3:0], 2'b00};
      rem <= rem_next;
    end
  end

endmodule
`default_nettype wire

[sv/mexp_datapath.sv]
// Datapath: accumulator, square, exponent shifter, multiplier and remainder unit.
`default_nettype none
module mexp_datapath
  import mexp_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    load,
  input  wire logic [OPERAND_BITS-1:0] base,
  input  wire logic [OPERAND_BITS-1:0] exponent,
  input  wire logic [OPERAND_BITS-1:0] modulus,
  input  wire ctrl_t                   ctl,
  output stat_t                        stat,
  output logic [OPERAND_BITS-1:0]      acc
);

  logic [OPERAND_BITS-1:0] sq;
  logic [OPERAND_BITS-1:0] e;
  logic [BIT_CNT_BITS-1:0] bits_left;
  logic [PROD_BITS-1:0]    red_in;
  logic                    red_done;
  logic [OPERAND_BITS-1:0] red_rem;
  logic                    wr_en;

  // operand select; the product is registered inside the remainder unit
  always_comb begin
    case (ctl.red_op)
      RED_BASE: red_in = {{(PROD_BITS-OPERAND_BITS){1'b0}}, base};
      RED_ACC:  red_in = PROD_BITS'(acc) * PROD_BITS'(sq);
      RED_SQ:   red_in = PROD_BITS'(sq) * PROD_BITS'(sq);
      default:  red_in = '0;
    endcase
  end

  mexp_modred u_red (
    .clk   (clk),
    .rst   (rst),
    .go    (ctl.go),
    .value (red_in),
    .m     (modulus),
    .done  (red_done),
    .rem   (red_rem)
  );

  assign wr_en = ctl.wait_red && red_done;

  always_ff @(posedge clk) begin
    if (load) begin
      acc       <= (modulus == OPERAND_BITS'(1)) ? '0 : OPERAND_BITS'(1);
      e         <= exponent;
      bits_left <= BIT_CNT_BITS'(OPERAND_BITS);
    end else if (wr_en) begin
      case (ctl.wr)
        WR_SQ:   sq <= red_rem;
        WR_ACC:  acc <= red_rem;
        default: ;
      endcase
      if (ctl.shift_e) begin
        e         <= e >> 1;
        bits_left <= bits_left - BIT_CNT_BITS'(1);
      end
    end
  end

  assign stat.red_done = red_done;
  assign stat.e_bit0   = e[0];
  assign stat.last_bit = (bits_left == BIT_CNT_BITS'(1));

endmodule
`default_nettype wire

[sv/modular_exponentiation.sv]
// Top level: modulus register, microcode sequencer and result register.
// Computes power_mod = base^exponent mod modulus for one word at a time. A word is taken
// when start is high and busy is low; busy then stays high until the result is out.
// The result appears on power_mod for exactly one cycle with done high and must be
// captured then: there is no backpressure. The base is reduced first, then the exponent
// is scanned LSB first by square-and-multiply. Each modular product uses one 16x16
// multiply followed by a restoring remainder unit that retires two bits per cycle, so
// one reduction is a launch step, the remainder iterations and a write-back step.
// The control program is a small ROM (one control word per step) walked by a step
// counter with conditional jumps. modulus may only be rewritten while busy is low; it
// resets to 19211. A modulus of zero yields 0; a modulus of one yields 0 for any input.
`default_nettype none
module modular_exponentiation
  import mexp_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic [OPERAND_BITS-1:0] base,
  input  wire logic [OPERAND_BITS-1:0] exponent,
  output logic                         busy,
  input  wire logic                    modulus_we,
  input  wire logic [OPERAND_BITS-1:0] modulus_data,
  output logic                         done,
  output logic [OPERAND_BITS-1:0]      power_mod
);

  logic                    accept;
  step_t                   pc;
  step_t                   pc_next;
  ctrl_t                   word;
  ctrl_t                   ctl;
  stat_t                   stat;
  logic                    take_jump;
  logic [OPERAND_BITS-1:0] modulus;
  logic [OPERAND_BITS-1:0] acc;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MODULUS_RESET;
    end else if (modulus_we) begin
      modulus <= modulus_data;
    end
  end

  assign busy   = (pc != S_IDLE);
  assign accept = start && !busy;

  // fetch; the idle step only launches the base reduction on an accepted word
  always_comb begin
    word = ucode(pc);
    ctl  = word;
    if (pc == S_IDLE) begin
      ctl.go = accept;
    end
  end

  always_comb begin
    case (word.jc)
      JC_NONE:       take_jump = 1'b0;
      JC_ALWAYS:     take_jump = 1'b1;
      JC_WAIT_START: take_jump = !start;
      JC_BIT_CLR:    take_jump = !stat.e_bit0;
      JC_MORE_BITS:  take_jump = !stat.last_bit;
      default:       take_jump = 1'b1;
    endcase
  end

  // hold on a wait step until the remainder unit finishes
  always_comb begin
    if (word.wait_red && !stat.red_done) begin
      pc_next = pc;
    end else if (take_jump) begin
      pc_next = word.target;
    end else begin
      pc_next = pc + STEP_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  mexp_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .base     (base),
    .exponent (exponent),
    .modulus  (modulus),
    .ctl      (ctl),
    .stat     (stat),
    .acc      (acc)
  );

  // result word
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= word.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (word.finish) begin
      power_mod <= (modulus == '0) ? '0 : acc;
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("done while busy");

  a_result_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (modulus == '0 || power_mod < modulus)) else $error("result not reduced");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy) else $error("accepted word did not start");

  a_done_from_finish: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(pc) == S_FINISH) else $error("done outside finish step");

endmodule
`default_nettype wire

[tb/sv/mexp_checker.sv]
// Checker for the modular exponentiation block: predicts each result and compares it.
`timescale 1ns / 1ps
module mexp_checker
  import mexp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic                    busy,
  input  logic [OPERAND_BITS-1:0] base,
  input  logic [OPERAND_BITS-1:0] exponent,
  input  logic                    modulus_we,
  input  logic [OPERAND_BITS-1:0] modulus_data,
  input  logic                    done,
  input  logic [OPERAND_BITS-1:0] power_mod,
  output int                      errors,
  output int                      pending
);

  logic [OPERAND_BITS-1:0] modulus_copy;
  logic [OPERAND_BITS-1:0] expected_power[$];

  // square-and-multiply, LSB first, every product reduced
  function automatic logic [OPERAND_BITS-1:0] expmod_predict(
      input logic [OPERAND_BITS-1:0] b,
      input logic [OPERAND_BITS-1:0] e,
      input logic [OPERAND_BITS-1:0] m);
    logic [63:0] acc;
    logic [63:0] sq;
    if (m == '0) return '0;   // no reduction possible
    acc = 64'(1) % 64'(m);
    sq  = 64'(b) % 64'(m);
    for (int i = 0; i < OPERAND_BITS; i++) begin
      if (e[i]) acc = (acc * sq) % 64'(m);
      sq = (sq * sq) % 64'(m);
    end
    return acc[OPERAND_BITS-1:0];
  endfunction

  always @(posedge clk) begin
    logic [OPERAND_BITS-1:0] want;
    if (rst) begin
      modulus_copy = MODULUS_RESET;
      expected_power.delete();
      errors = 0;
    end else begin
      // retire the oldest word first so a same-edge accept cannot be matched
      if (done) begin
        if (expected_power.size() == 0) begin
          $error("power_mod: result with no word pending, actual %0d", power_mod);
          errors++;
        end else begin
          want = expected_power.pop_front();
          if (power_mod !== want) begin
            $error("power_mod mismatch: expected %0d, actual %0d", want, power_mod);
            errors++;
          end
        end
      end
      if (start && !busy)
        expected_power.push_back(expmod_predict(base, exponent, modulus_copy));
      if (modulus_we) modulus_copy = modulus_data;
    end
    pending = expected_power.size();
  end

endmodule

[tb/sv/tb_modular_exponentiation.sv]
// Testbench top: clock, reset, stimulus and verdict for the modular exponentiation block.
`timescale 1ns / 1ps
module tb_modular_exponentiation;
  import mexp_pkg::*;

  logic                    clk;
  logic                    rst;
  logic                    start;
  logic [OPERAND_BITS-1:0] base;
  logic [OPERAND_BITS-1:0] exponent;
  logic                    busy;
  logic                    modulus_we;
  logic [OPERAND_BITS-1:0] modulus_data;
  logic                    done;
  logic [OPERAND_BITS-1:0] power_mod;
  int                      errors;
  int                      pending;

  // modulus the block currently holds, used to aim bases near it
  logic [OPERAND_BITS-1:0] cur_modulus;

  localparam int RANDOM_PHASES = 8;
  localparam int WORDS_PER_PHASE = 120;

  // 12 ns period
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  modular_exponentiation i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .base         (base),
    .exponent     (exponent),
    .busy         (busy),
    .modulus_we   (modulus_we),
    .modulus_data (modulus_data),
    .done         (done),
    .power_mod    (power_mod)
  );

  mexp_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .base         (base),
    .exponent     (exponent),
    .modulus_we   (modulus_we),
    .modulus_data (modulus_data),
    .done         (done),
    .power_mod    (power_mod),
    .errors       (errors),
    .pending      (pending)
  );

  // Present one word from the falling edge and hold it until the block takes it.
  // start stays high across back-to-back words of a burst; the caller lowers it.
  task automatic send_word(input logic [OPERAND_BITS-1:0] b, input logic [OPERAND_BITS-1:0] e);
    @(negedge clk);
    start    <= 1'b1;
    base     <= b;
    exponent <= e;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Drop start and let every outstanding word come back.
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0 || busy) @(negedge clk);
  endtask

  // Modulus only changes with the block idle and nothing in flight.
  task automatic set_modulus(input logic [OPERAND_BITS-1:0] m);
    drain();
    modulus_we   <= 1'b1;
    modulus_data <= m;
    @(negedge clk);
    modulus_we <= 1'b0;
    cur_modulus = m;
  endtask

  // Gap after a burst. Most gaps land while the block is still grinding on the
  // last word; some wait for idle first so start also rises on an idle block,
  // and a few hold off until every result is back.
  task automatic idle_gap();
    int mode;
    mode = $urandom_range(0, 99);
    @(negedge clk);
    start <= 1'b0;
    if (mode < 40) begin
      // one low cycle only
    end else if (mode < 70) begin
      repeat ($urandom_range(1, 20)) @(negedge clk);
    end else if (mode < 87) begin
      while (busy) @(negedge clk);
      repeat ($urandom_range(0, 6)) @(negedge clk);
    end else if (mode < 96) begin
      repeat ($urandom_range(1, 650)) @(negedge clk);
    end else begin
      while (pending != 0) @(negedge clk);
    end
  endtask

  // Random word: bases biased to the edges and around the modulus, exponents
  // mostly full width with some tiny, single-bit and extreme values.
  task automatic pick_word(output logic [OPERAND_BITS-1:0] b, output logic [OPERAND_BITS-1:0] e);
    case ($urandom_range(0, 9))
      0:       b = '0;
      1:       b = '1;
      2:       b = OPERAND_BITS'(cur_modulus - 1);
      3:       b = OPERAND_BITS'(cur_modulus + $urandom_range(0, 3));
      4:       b = OPERAND_BITS'($urandom_range(1, 5));
      default: b = OPERAND_BITS'($urandom);
    endcase
    case ($urandom_range(0, 9))
      0:       e = '0;
      1:       e = '1;
      2:       e = OPERAND_BITS'(1) << $urandom_range(0, OPERAND_BITS - 1);
      3, 4:    e = OPERAND_BITS'($urandom_range(0, 24));
      default: e = OPERAND_BITS'($urandom);
    endcase
  endtask

  task automatic run_random(input int count);
    int sent;
    int burst;
    logic [OPERAND_BITS-1:0] b;
    logic [OPERAND_BITS-1:0] e;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 16);
      for (int k = 0; k < burst && sent < count; k++) begin
        pick_word(b, e);
        send_word(b, e);
        sent++;
      end
      idle_gap();
    end
  endtask

  // Modulus for each random phase: extremes, a large prime, tiny and random.
  function automatic logic [OPERAND_BITS-1:0] phase_modulus(input int p);
    case (p)
      0:       return OPERAND_BITS'(19211);
      1:       return '1;
      2:       return OPERAND_BITS'($urandom_range(2, 255));
      3:       return OPERAND_BITS'(65521);
      4:       return OPERAND_BITS'(3);
      5:       return OPERAND_BITS'($urandom_range(256, 65535));
      default: return OPERAND_BITS'($urandom_range(1, 65535));
    endcase
  endfunction

  initial begin
    int waited;
    rst          = 1'b1;
    start        = 1'b0;
    base         = '0;
    exponent     = '0;
    modulus_we   = 1'b0;
    modulus_data = '0;
    cur_modulus  = MODULUS_RESET;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // Directed words at the reset modulus: edges of both fields, base equal to
    // and just above the modulus, zero base with nonzero exponent, sparse and
    // dense exponent patterns.
    send_word(16'd0, 16'd0);
    send_word(16'd0, 16'd1);
    send_word(16'd0, 16'hFFFF);
    send_word(16'hFFFF, 16'd0);
    send_word(16'hFFFF, 16'hFFFF);
    idle_gap();
    send_word(16'd1, 16'hFFFF);
    send_word(16'd2, 16'd10);
    send_word(16'd19211, 16'd5);
    send_word(16'd19212, 16'd3);
    idle_gap();
    send_word(16'hFFFF, 16'd1);
    send_word(16'd5, 16'h8000);
    send_word(16'd3, 16'hAAAA);
    send_word(16'd7, 16'h5555);

    // modulus of one: everything folds to zero, zero exponent included
    set_modulus(16'd1);
    send_word(16'd5, 16'd0);
    send_word(16'hFFFF, 16'hFFFF);

    // modulus of zero: result pinned at zero
    set_modulus(16'd0);
    send_word(16'd5, 16'd3);
    send_word(16'd0, 16'd0);
    send_word(16'hFFFF, 16'hFFFF);

    // largest modulus
    set_modulus(16'hFFFF);
    send_word(16'hFFFE, 16'hFFFF);
    send_word(16'd2, 16'd16);
    send_word(16'hFFFF, 16'd1);
    send_word(16'd0, 16'd0);

    // random phases, each under its own modulus
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_modulus(phase_modulus(p));
      run_random(WORDS_PER_PHASE);
    end

    @(negedge clk);
    start <= 1'b0;
    // allow several full-length words before giving up
    waited = 0;
    while (pending != 0 && waited < 5000) begin
      @(negedge clk);
      waited++;
    end
    // catch any stray strobe after the last word
    repeat (700) @(negedge clk);
    if (pending != 0) $error("power_mod: %0d words never produced a result", pending);

    if (errors == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // ~1000 words plus gaps is under 9 ms; allow far more
  initial begin
    #(40_000_000);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
